### rtl/core/evhp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package evhp_pkg;

  typedef enum logic [1:0] {
    PH_ADDR  = 2'd0,
    PH_WORDS = 2'd1,
    PH_SKIP  = 2'd2
  } phase_t;

  localparam logic [1:0] KIND_TAG = 2'd0;
  localparam logic [1:0] KIND_HDR = 2'd1;
  localparam logic [1:0] KIND_ERR = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_SHORT = 2'd1;
  localparam logic [1:0] STAT_MANY  = 2'd2;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CTAG = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STAG = 2'd1;

  localparam logic [15:0] CTAG_RESET = 16'h8100;
  localparam logic [15:0] STAG_RESET = 16'h88A8;

  localparam logic [3:0] MAC_BYTES = 4'd6;
  localparam logic [3:0] ADDR_LAST = 4'd11;
  localparam logic [5:0] HDR_LEN   = 6'd14;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } beat_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] tag_tpid;
    logic [2:0]  tag_pcp;
    logic        tag_dei;
    logic [11:0] tag_vid;
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic [15:0] eth_type;
    logic [5:0]  data_offset;
    logic [3:0]  tag_count;
    logic [1:0]  status;
  } result_t;

endpackage

`default_nettype wire

### rtl/core/evhp_in_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module evhp_in_reg (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire logic [7:0]     data_byte,
  input  wire logic           last_byte,
  input  wire logic           can_load,
  output logic                advance,
  output evhp_pkg::beat_t     beat
);
  import evhp_pkg::*;

  logic held;

  assign advance  = held && can_load;
  assign in_stall = held && !can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && !in_stall) begin
      held <= 1'b1;
    end else if (advance) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      beat.data <= data_byte;
      beat.last <= last_byte;
    end
  end

endmodule

`default_nettype wire

### rtl/core/evhp_parse.sv
`timescale 1ns / 1ps
`default_nettype none

module evhp_parse #(
  parameter int MAX_TAGS = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  input  wire logic [evhp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]                    cfg_data,
  input  wire logic                           advance,
  input  wire evhp_pkg::beat_t                beat,
  output logic                                res_valid,
  output evhp_pkg::result_t                   res
);
  import evhp_pkg::*;

  logic [15:0] ctag_tpid;
  logic [15:0] stag_tpid;

  phase_t      phase, phase_next;
  logic [3:0]  pos, pos_next;
  logic [47:0] dst, dst_next;
  logic [47:0] src, src_next;
  logic [7:0]  hold, hold_next;
  logic [15:0] pending, pending_next;
  logic [3:0]  tags, tags_next;
  logic        in_ctl, in_ctl_next;
  logic [15:0] word;

  assign word = {hold, beat.data};

  always_ff @(posedge clk) begin
    if (rst) begin
      ctag_tpid <= CTAG_RESET;
      stag_tpid <= STAG_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_CTAG) begin
        ctag_tpid <= cfg_data;
      end else if (cfg_index == CFG_STAG) begin
        stag_tpid <= cfg_data;
      end
    end
  end

  always_comb begin
    phase_next   = phase;
    pos_next     = pos;
    dst_next     = dst;
    src_next     = src;
    hold_next    = hold;
    pending_next = pending;
    tags_next    = tags;
    in_ctl_next  = in_ctl;
    res          = '0;
    res_valid    = 1'b0;

    unique case (phase)
      PH_ADDR: begin
        if (pos < MAC_BYTES) begin
          dst_next = {dst[39:0], beat.data};
        end else begin
          src_next = {src[39:0], beat.data};
        end
        if (pos == ADDR_LAST) begin
          pos_next   = '0;
          phase_next = PH_WORDS;
        end else begin
          pos_next = pos + 4'd1;
        end
        if (beat.last) begin
          res_valid     = 1'b1;
          res.kind      = KIND_ERR;
          res.tag_count = tags;
          res.status    = STAT_SHORT;
        end
      end
      PH_WORDS: begin
        if (pos == '0) begin
          hold_next = beat.data;
          pos_next  = 4'd1;
          if (beat.last) begin
            res_valid     = 1'b1;
            res.kind      = KIND_ERR;
            res.tag_count = tags;
            res.status    = STAT_SHORT;
          end
        end else begin
          pos_next = '0;
          if (in_ctl) begin
            in_ctl_next = 1'b0;
            tags_next   = tags + 4'd1;
            res_valid   = 1'b1;
            if (beat.last) begin
              // frame cut on the tag control word: error replaces the tag
              res.kind      = KIND_ERR;
              res.tag_count = tags + 4'd1;
              res.status    = STAT_SHORT;
            end else begin
              res.kind     = KIND_TAG;
              res.tag_tpid = pending;
              res.tag_pcp  = word[15:13];
              res.tag_dei  = word[12];
              res.tag_vid  = word[11:0];
            end
          end else if (word == ctag_tpid || word == stag_tpid) begin
            if (tags >= 4'(MAX_TAGS)) begin
              res_valid     = 1'b1;
              res.kind      = KIND_ERR;
              res.tag_count = tags;
              res.status    = STAT_MANY;
              phase_next    = PH_SKIP;
            end else begin
              pending_next = word;
              in_ctl_next  = 1'b1;
              if (beat.last) begin
                res_valid     = 1'b1;
                res.kind      = KIND_ERR;
                res.tag_count = tags;
                res.status    = STAT_SHORT;
              end
            end
          end else begin
            res_valid       = 1'b1;
            res.kind        = KIND_HDR;
            res.dst_mac     = dst;
            res.src_mac     = src;
            res.eth_type    = word;
            res.data_offset = HDR_LEN + {tags, 2'b00};
            res.tag_count   = tags;
            res.status      = STAT_OK;
            phase_next      = PH_SKIP;
          end
        end
      end
      default: begin
        // skip to end of frame
      end
    endcase

    if (beat.last) begin
      phase_next  = PH_ADDR;
      pos_next    = '0;
      tags_next   = '0;
      in_ctl_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_ADDR;
      pos    <= '0;
      tags   <= '0;
      in_ctl <= 1'b0;
    end else if (advance) begin
      phase  <= phase_next;
      pos    <= pos_next;
      tags   <= tags_next;
      in_ctl <= in_ctl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dst     <= dst_next;
      src     <= src_next;
      hold    <= hold_next;
      pending <= pending_next;
    end
  end

  a_tag_needs_ctl: assert property (@(posedge clk) disable iff (rst)
    (advance && res_valid && res.kind == KIND_TAG) |-> in_ctl)
    else $error("tag result without a pending TPID");

  a_tags_bounded: assert property (@(posedge clk) disable iff (rst)
    tags <= 4'(MAX_TAGS))
    else $error("tag count above limit");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (pos <= ADDR_LAST) && (phase != PH_WORDS || pos <= 4'd1))
    else $error("byte position out of range");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (advance && beat.last) |=> (phase == PH_ADDR && tags == '0 && !in_ctl && pos == '0))
    else $error("frame state not cleared after last byte");

endmodule

`default_nettype wire

### rtl/core/evhp_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module evhp_out_reg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          advance,
  input  wire logic          res_valid,
  input  wire evhp_pkg::result_t res,
  output logic               can_load,
  output logic               out_valid,
  input  wire logic          out_stall,
  output evhp_pkg::result_t  out_res
);
  import evhp_pkg::*;

  logic load;

  assign can_load = !out_valid || !out_stall;
  assign load     = advance && res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= res;
    end
  end

endmodule

`default_nettype wire

### rtl/core/ethernet_vlan_header_parser.sv
`timescale 1ns / 1ps
`default_nettype none

// Ethernet 802.1Q / 802.1ad header parser. Frame bytes come in one per beat in
// wire order, last_byte marking the end of the frame. The first twelve bytes
// are the destination and source MACs; then 16-bit big-endian words are read.
// A word matching the C-tag or S-tag TPID register starts a tag, and the next
// word yields one tag result (kind 0: TPID, PCP, DEI, VID). The first non-TPID
// word is the EtherType: one header result (kind 1) with both MACs, EtherType,
// payload offset and tag count, after which the rest of the frame is dropped.
// A frame ending before the EtherType gives an error result (kind 2, status 1);
// a TPID seen with MAX_TAGS tags already parsed gives status 2. Each byte sits
// in the input register, passes the single parse stage and lands in the result
// register, so one beat per clock is sustained while no result waits under
// out_stall; results are presented straight from the result register.
// The input stalls only while a result is held in the output register under
// out_stall. TPID registers are written at index 0 (C-tag) and 1 (S-tag);
// cfg_ready is always high, other indexes are dropped. Write them only while
// the block is idle.
module ethernet_vlan_header_parser #(
  parameter int MAX_TAGS = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst,

  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [evhp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]                    cfg_data,

  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [7:0]                     data_byte,
  input  wire logic                           last_byte,

  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [1:0]                          kind,
  output logic [15:0]                         tag_tpid,
  output logic [2:0]                          tag_pcp,
  output logic                                tag_dei,
  output logic [11:0]                         tag_vid,
  output logic [47:0]                         dst_mac,
  output logic [47:0]                         src_mac,
  output logic [15:0]                         eth_type,
  output logic [5:0]                          data_offset,
  output logic [3:0]                          tag_count,
  output logic [1:0]                          status
);
  import evhp_pkg::*;

  beat_t   beat;
  result_t res;
  result_t out_res;
  logic    advance;
  logic    can_load;
  logic    res_valid;

  // config port never back-pressures
  assign cfg_ready = 1'b1;

  // input register: one byte beat waiting for the parse stage
  evhp_in_reg u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .can_load  (can_load),
    .advance   (advance),
    .beat      (beat)
  );

  // parse stage: frame state update and result build in one pass
  evhp_parse #(
    .MAX_TAGS (MAX_TAGS)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .advance   (advance),
    .beat      (beat),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register toward the downstream side
  evhp_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .res_valid (res_valid),
    .res       (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign kind        = out_res.kind;
  assign tag_tpid    = out_res.tag_tpid;
  assign tag_pcp     = out_res.tag_pcp;
  assign tag_dei     = out_res.tag_dei;
  assign tag_vid     = out_res.tag_vid;
  assign dst_mac     = out_res.dst_mac;
  assign src_mac     = out_res.src_mac;
  assign eth_type    = out_res.eth_type;
  assign data_offset = out_res.data_offset;
  assign tag_count   = out_res.tag_count;
  assign status      = out_res.status;

endmodule

`default_nettype wire

### tb/sv/tb_ethernet_vlan_header_parser.sv
`timescale 1ns / 1ps

module tb_ethernet_vlan_header_parser;
  import evhp_pkg::*;

  localparam int MAX_TAGS    = 8;
  localparam int CYCLE_LIMIT = 400_000;
  localparam int PHASE_BEATS = 170;      // byte beats per config phase, six phases

  // indexes past the register list; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = CFG_STAG + 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = '1;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_data  = '0;

  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic [7:0]           data_byte = '0;
  logic                 last_byte = 1'b0;

  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           kind;
  logic [15:0]          tag_tpid;
  logic [2:0]           tag_pcp;
  logic                 tag_dei;
  logic [11:0]          tag_vid;
  logic [47:0]          dst_mac;
  logic [47:0]          src_mac;
  logic [15:0]          eth_type;
  logic [5:0]           data_offset;
  logic [3:0]           tag_count;
  logic [1:0]           status;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int cycles      = 0;
  int beats_sent  = 0;
  int frames_sent = 0;

  ethernet_vlan_header_parser #(.MAX_TAGS(MAX_TAGS)) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .last_byte     (last_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .kind          (kind),
    .tag_tpid      (tag_tpid),
    .tag_pcp       (tag_pcp),
    .tag_dei       (tag_dei),
    .tag_vid       (tag_vid),
    .dst_mac       (dst_mac),
    .src_mac       (src_mac),
    .eth_type      (eth_type),
    .data_offset   (data_offset),
    .tag_count     (tag_count),
    .status        (status)
  );

  // Byte-level parse tracker: mirrors the header walk, queues the tag/header/error
  // results each byte should produce, and checks what the block hands back.
  class vlan_parse_tracker;
    logic [15:0] ctag, stag;
    int          max_tags;
    logic [5:0]  pos;
    phase_t      phase;
    logic [47:0] dst_sr, src_sr;
    logic [7:0]  hold_hi;
    logic [15:0] pend_tpid;
    logic [3:0]  seen;
    logic        in_ctrl;
    result_t     parse_due[$];
    int          faults, n_tags, n_hdrs, n_errs;

    function new(int limit);
      max_tags = limit;
      ctag     = CTAG_RESET;
      stag     = STAG_RESET;
      faults   = 0;
      n_tags   = 0;
      n_hdrs   = 0;
      n_errs   = 0;
      restart_frame();
    endfunction

    function void restart_frame();
      pos       = '0;
      phase     = PH_ADDR;
      dst_sr    = '0;
      src_sr    = '0;
      hold_hi   = '0;
      pend_tpid = '0;
      seen      = '0;
      in_ctrl   = 1'b0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
      if (idx == CFG_CTAG) ctag = val;
      else if (idx == CFG_STAG) stag = val;
    endfunction

    function int pending();
      return parse_due.size();
    endfunction

    function result_t error_result(logic [1:0] code);
      result_t r;
      r           = '0;
      r.kind      = KIND_ERR;
      r.tag_count = seen;
      r.status    = code;
      return r;
    endfunction

    function void parse_byte(logic [7:0] b, logic fin);
      result_t     r;
      logic [15:0] w;
      bit          hit;
      r   = '0;
      hit = 1'b0;
      w   = {hold_hi, b};
      case (phase)
        PH_ADDR: begin
          if (pos < 6'(MAC_BYTES)) dst_sr = {dst_sr[39:0], b};
          else src_sr = {src_sr[39:0], b};
          pos = pos + 6'd1;
          if (pos > 6'(ADDR_LAST)) begin
            pos   = '0;
            phase = PH_WORDS;
          end
          if (fin) begin
            r   = error_result(STAT_SHORT);
            hit = 1'b1;
          end
        end
        PH_WORDS: begin
          if (pos == '0) begin
            hold_hi = b;
            pos     = 6'd1;
            if (fin) begin
              r   = error_result(STAT_SHORT);
              hit = 1'b1;
            end
          end else begin
            pos = '0;
            if (in_ctrl) begin
              // tag control word done; a frame ending here reports short instead
              in_ctrl = 1'b0;
              seen    = seen + 4'd1;
              if (fin) begin
                r = error_result(STAT_SHORT);
              end else begin
                r.kind     = KIND_TAG;
                r.tag_tpid = pend_tpid;
                r.tag_pcp  = w[15:13];
                r.tag_dei  = w[12];
                r.tag_vid  = w[11:0];
              end
              hit = 1'b1;
            end else if (w == ctag || w == stag) begin
              if (int'(seen) >= max_tags) begin
                r     = error_result(STAT_MANY);
                phase = PH_SKIP;
                hit   = 1'b1;
              end else begin
                pend_tpid = w;
                in_ctrl   = 1'b1;
                if (fin) begin
                  r   = error_result(STAT_SHORT);
                  hit = 1'b1;
                end
              end
            end else begin
              r.kind        = KIND_HDR;
              r.dst_mac     = dst_sr;
              r.src_mac     = src_sr;
              r.eth_type    = w;
              r.data_offset = HDR_LEN + {seen, 2'b00};
              r.tag_count   = seen;
              r.status      = STAT_OK;
              phase         = PH_SKIP;
              hit           = 1'b1;
            end
          end
        end
        default: ;   // skipping the rest of the frame
      endcase
      if (fin) restart_frame();
      if (hit) parse_due = {parse_due, r};
    endfunction

    function void check_field(string label, logic [47:0] want, logic [47:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", label, want, got);
        faults++;
      end
    endfunction

    function void match_parse(result_t got);
      result_t want;
      if (parse_due.size() == 0) begin
        $error("result beat with nothing awaited (kind %0d)", got.kind);
        faults++;
        return;
      end
      want = parse_due.pop_front();
      case (want.kind)
        KIND_TAG: n_tags++;
        KIND_HDR: n_hdrs++;
        default:  n_errs++;
      endcase
      check_field("kind",        48'(want.kind),        48'(got.kind));
      check_field("tag_tpid",    48'(want.tag_tpid),    48'(got.tag_tpid));
      check_field("tag_pcp",     48'(want.tag_pcp),     48'(got.tag_pcp));
      check_field("tag_dei",     48'(want.tag_dei),     48'(got.tag_dei));
      check_field("tag_vid",     48'(want.tag_vid),     48'(got.tag_vid));
      check_field("dst_mac",     want.dst_mac,          got.dst_mac);
      check_field("src_mac",     want.src_mac,          got.src_mac);
      check_field("eth_type",    48'(want.eth_type),    48'(got.eth_type));
      check_field("data_offset", 48'(want.data_offset), 48'(got.data_offset));
      check_field("tag_count",   48'(want.tag_count),   48'(got.tag_count));
      check_field("status",      48'(want.status),      48'(got.status));
    endfunction
  endclass

  vlan_parse_tracker tracker = new(MAX_TAGS);

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog. Slowest legal run is well under a tenth of this.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("** ethernet_vlan_header_parser: FAILED **");
      $finish;
    end
  end

  // Receiver back-pressure, redrawn every falling edge.
  always @(negedge clk)
    out_stall <= ($urandom_range(99) < rx_idle_pct);

  // Sample both handshakes at the rising edge. Results are checked before the
  // byte beat of the same edge is noted; the block cannot answer a byte at the edge that takes it.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall)
        tracker.match_parse({kind, tag_tpid, tag_pcp, tag_dei, tag_vid, dst_mac, src_mac,
                             eth_type, data_offset, tag_count, status});
      if (in_valid && !in_stall)
        tracker.parse_byte(data_byte, last_byte);
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is
  // taken with in_valid still high, so the next call can drive straight on.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
    @(negedge clk);
  endtask

  // Hold off the sender until every queued result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Writes both TPIDs plus one write past the register list. cfg_valid stays
  // high across back-to-back beats and drops once at the end.
  task automatic program_tpids(input logic [15:0] c_val, input logic [15:0] s_val);
    logic [CFG_IDX_W-1:0] idx [3];
    logic [15:0]          val [3];
    idx[0] = CFG_CTAG;
    val[0] = c_val;
    idx[1] = CFG_STAG;
    val[1] = s_val;
    idx[2] = $urandom_range(1) ? CFG_UNUSED_LO : CFG_UNUSED_HI;
    val[2] = 16'($urandom);
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      tracker.set_reg(idx[i], val[i]);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // One frame: mostly well-formed (addresses, tags, EtherType, a few payload
  // bytes), some with too many tags, some cut short at an awkward byte, and a
  // few of plain noise. Returns the number of bytes sent.
  task automatic send_frame(output int n_beats);
    logic [7:0]  fb[$];
    logic [15:0] w;
    int          ntags, keep, sel, hdr_len, fill;
    ntags = 0;
    sel   = $urandom_range(99);
    if (sel < 5) begin
      keep = $urandom_range(1, 30);
      repeat (keep) fb = {fb, 8'($urandom)};
      hdr_len = keep;
    end else begin
      for (int a = 0; a < 2; a++) begin
        fill = $urandom_range(9);
        for (int i = 0; i < 6; i++)
          fb = {fb, (fill == 0 ? 8'h00 : fill == 1 ? 8'hFF : 8'($urandom))};
      end
      sel = $urandom_range(99);
      if (sel < 55) ntags = $urandom_range(0, 2);
      else if (sel < 88) ntags = $urandom_range(3, MAX_TAGS);
      else ntags = MAX_TAGS + $urandom_range(1, 2);
      for (int t = 0; t < ntags; t++) begin
        w = $urandom_range(1) ? tracker.ctag : tracker.stag;
        fb = {fb, w[15:8], w[7:0]};
        case ($urandom_range(7))
          0:       w = 16'h0000;
          1:       w = 16'hFFFF;
          default: w = 16'($urandom);
        endcase
        fb = {fb, w[15:8], w[7:0]};
      end
      case ($urandom_range(9))
        0:       w = 16'h0800;
        1:       w = 16'hFFFF;
        2:       w = 16'h0000;
        default: w = 16'($urandom);
      endcase
      fb = {fb, w[15:8], w[7:0]};
      hdr_len = fb.size();
      repeat ($urandom_range(0, 5)) fb = {fb, 8'($urandom)};
      keep = fb.size();
      sel  = $urandom_range(99);
      if (sel < 10)
        keep = $urandom_range(1, hdr_len - 1);
      else if (sel < 16 && ntags > 0)
        keep = 12 + 4 * $urandom_range(1, ntags);   // ends on a finished tag control word
      else if (sel < 20 && ntags > 0)
        keep = 10 + 4 * $urandom_range(1, ntags);   // ends right after a TPID
    end
    n_beats = 0;
    for (int i = 0; i < keep; i++) begin
      send_byte(fb[i], i == keep - 1);
      n_beats++;
    end
    frames_sent++;
  endtask

  initial begin
    int got_beats, phase_beats;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    tx_idle_pct = 31;
    rx_idle_pct = 45;

    // Directed: a one-byte frame dies inside the destination address; then the
    // shortest complete frame with all-ones / all-zeros addresses and a single
    // trailing payload byte that must be dropped.
    send_byte(8'h00, 1'b1);
    repeat (6) send_byte(8'hFF, 1'b0);
    repeat (6) send_byte(8'h00, 1'b0);
    send_byte(8'h08, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    frames_sent += 2;

    // Six config phases. Sender/receiver idling: 31/45, then 45/31, then none.
    for (int ph = 0; ph < 6; ph++) begin
      drain_results();
      repeat (4) @(negedge clk);   // let a trailing no-result byte clear the pipe
      case (ph)
        0: ;                                         // reset TPIDs
        1: program_tpids(16'h0000, 16'hFFFF);
        2: program_tpids(16'hFFFF, 16'h0000);
        3: begin
          got_beats = $urandom;
          program_tpids(16'(got_beats), 16'(got_beats));   // both TPIDs equal
        end
        4: program_tpids(16'($urandom), 16'($urandom));
        default: program_tpids(CTAG_RESET, STAG_RESET);
      endcase
      tx_idle_pct = (ph < 2) ? 31 : (ph < 4) ? 45 : 0;
      rx_idle_pct = (ph < 2) ? 45 : (ph < 4) ? 31 : 0;
      phase_beats = 0;
      while (phase_beats < PHASE_BEATS) begin
        send_frame(got_beats);
        phase_beats += got_beats;
        if ($urandom_range(99) < 5) drain_results();
      end
    end

    drain_results();
    repeat (8) @(posedge clk);

    $display("Sent %0d beats in %0d frames over six TPID settings and three idle mixes.",
             beats_sent, frames_sent);
    $display("Checked %0d tag, %0d header and %0d error results; %0d mismatches.",
             tracker.n_tags, tracker.n_hdrs, tracker.n_errs, tracker.faults);
    if (tracker.faults == 0 && tracker.pending() == 0)
      $display("** ethernet_vlan_header_parser: PASSED **");
    else
      $display("** ethernet_vlan_header_parser: FAILED **");
    $finish;
  end

endmodule

### filelist.f
rtl/core/evhp_pkg.sv
rtl/core/evhp_in_reg.sv
rtl/core/evhp_parse.sv
rtl/core/evhp_out_reg.sv
rtl/core/ethernet_vlan_header_parser.sv
tb/sv/tb_ethernet_vlan_header_parser.sv
